// ===== rtl/core/palette_refcount_voxel_store_assert.svh =====
// Assertion macros for the palette voxel store.
// Included inside module bodies that have clk and rst in scope.
`ifndef PALETTE_REFCOUNT_VOXEL_STORE_ASSERT_SVH
`define PALETTE_REFCOUNT_VOXEL_STORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge outside reset.
`define PCVS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("palette store check failed");
// Next-cycle implication, checked at every clock edge outside reset.
`define PCVS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("palette store check failed");
`else
`define PCVS_ASSERT_IMP(name, ante, cons)
`define PCVS_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== rtl/core/pcvs_pkg.sv =====
// Shared constants, codes and the sequencer state type of the palette voxel store.
// No dependencies.
package pcvs_pkg;

  localparam int DEF_CELLS         = 4096;
  localparam int DEF_PALETTE_DEPTH = 64;
  localparam int DEF_VOXEL_BITS    = 16;

  // Fixed field widths of the stream items.
  localparam int CELL_INDEX_W = 12;
  localparam int VOXEL_W      = 16;
  localparam int SLOT_W       = 6;
  localparam int S_TDATA_W    = 32;
  localparam int M_TDATA_W    = 24;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_OLD,
    ST_SCAN,
    ST_DECIDE,
    ST_WR2,
    ST_DONE
  } pcvs_state_t;

endpackage

// ===== rtl/core/pcvs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module pcvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/palette_refcount_voxel_store.sv =====
// Top level of the palette-compressed voxel store with per-slot reference counts.
// Depends on pcvs_pkg, pcvs_ram and palette_refcount_voxel_store_assert.svh.

// Each cell holds a palette slot number and each palette slot holds a voxel value and
// a reference count. A read item returns the voxel and slot of the cell. A write item
// drops one reference from the cell's old slot, then points the cell at the lowest slot
// in use that already holds the value, or rewrites the old slot in place when it has no
// references left, or reuses the lowest unreferenced slot, or appends a new slot. When
// the palette is full the write is rejected, nothing changes and status reads 1. A cell
// index at or beyond CELLS changes nothing and returns all zeros. After reset the block
// clears the cell memory and accepts no item during that pass. The cell slots live in
// one RAM and the palette (voxel and count side by side) in a second; both have a
// registered read. An item waits in its last state until the output register is free.
// A read item passes through the cell read and the old slot read. A write item passes
// through the cell read, the old slot read, the sequential palette scan, the decision
// and, when two palette entries are updated, a second palette write. The block takes no
// new item until the previous one has loaded its result into the output register. That
// result is presented in the same cycle in which the next item can be accepted. The
// single palette scan finds the matching slot and the lowest free slot in the same pass,
// one slot per cycle through the palette read port.
// The next item is accepted while the previous result still waits in the output register.
module palette_refcount_voxel_store #(
  parameter int CELLS         = pcvs_pkg::DEF_CELLS,
  parameter int PALETTE_DEPTH = pcvs_pkg::DEF_PALETTE_DEPTH,
  parameter int VOXEL_BITS    = pcvs_pkg::DEF_VOXEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // cell_index [11:0], voxel_value [27:12], zero fill [31:28]
  input  logic [pcvs_pkg::S_TDATA_W-1:0] s_tdata,
  // mode [0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // voxel_out [15:0], palette_slot [21:16], zero fill [23:22]
  output logic [pcvs_pkg::M_TDATA_W-1:0] m_tdata,
  // status [0]
  output logic                           m_tuser
);
  import pcvs_pkg::*;
  `include "palette_refcount_voxel_store_assert.svh"

  // Slot number, slot fill count, reference count and stored voxel widths.
  localparam int SW  = $clog2(PALETTE_DEPTH);
  localparam int UW  = $clog2(PALETTE_DEPTH + 1);
  localparam int CW  = $clog2(CELLS + 1);
  localparam int VW  = (VOXEL_BITS < VOXEL_W) ? VOXEL_BITS : VOXEL_W;
  localparam int PW  = VW + CW;
  // Only cells reachable through the index field are stored.
  localparam int MEMCELLS = (CELLS < 2**CELL_INDEX_W) ? CELLS : 2**CELL_INDEX_W;
  localparam int CAW = $clog2(MEMCELLS);
  // Bits of the slot number that reach the result field.
  localparam int SOW = (SW < SLOT_W) ? SW : SLOT_W;

  pcvs_state_t state, state_next;

  // Item fields.
  logic                    in_mode;
  logic [CELL_INDEX_W-1:0] in_idx;
  logic [VOXEL_W-1:0]      in_val_full;
  logic                    in_range;
  logic                    mode_r;
  logic [CELL_INDEX_W-1:0] idx_r;
  logic [VW-1:0]           val_r;

  // Old slot of the cell, its voxel and its count after the decrement.
  logic [SW-1:0] old_slot;
  logic [VW-1:0] old_voxel;
  logic [CW-1:0] left;

  // Palette scan.
  logic [SW-1:0] chk;
  logic [UW-1:0] chk_inc;
  logic          scan_hit;
  logic          scan_last;
  logic          hit;
  logic [SW-1:0] m_slot;
  logic [CW-1:0] m_count;
  logic          free_ok;
  logic [SW-1:0] free_slot;

  logic [UW-1:0] slots_in_use, slots_in_use_next;
  logic [CAW-1:0] clr;

  // Second palette write and the pending result.
  logic [SW-1:0] wr2_slot, wr2_slot_next;
  logic [PW-1:0] wr2_word, wr2_word_next;
  logic [VW-1:0] res_voxel, res_voxel_next;
  logic [SW-1:0] res_slot, res_slot_next;
  logic          res_status, res_status_next;
  logic          out_load;
  logic [VOXEL_W-1:0] out_voxel;
  logic [SLOT_W-1:0]  out_slot;

  // Memory ports.
  logic           cell_we;
  logic [CAW-1:0] cell_waddr;
  logic [SW-1:0]  cell_wdata;
  logic [CAW-1:0] cell_raddr;
  logic [SW-1:0]  cell_rdata;
  logic           pal_we;
  logic [SW-1:0]  pal_waddr;
  logic [PW-1:0]  pal_wdata;
  logic [SW-1:0]  pal_raddr;
  logic [PW-1:0]  pal_rdata;
  logic [VW-1:0]  rd_voxel;
  logic [CW-1:0]  rd_count;

  assign in_mode     = s_tuser;
  assign in_idx      = s_tdata[CELL_INDEX_W-1:0];
  assign in_val_full = s_tdata[CELL_INDEX_W +: VOXEL_W];
  assign in_range    = 32'(in_idx) < 32'(CELLS);

  assign rd_voxel  = pal_rdata[PW-1:CW];
  assign rd_count  = pal_rdata[CW-1:0];
  assign chk_inc   = UW'(chk) + UW'(1);
  assign scan_hit  = rd_voxel == val_r;
  assign scan_last = chk_inc >= slots_in_use;

  // Cell memory: one palette slot number per cell.
  pcvs_ram #(
    .WIDTH (SW),
    .DEPTH (MEMCELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  // Palette memory: voxel in the upper bits, reference count in the lower bits.
  pcvs_ram #(
    .WIDTH (PW),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  // Sequencer: next state, memory controls and the result.
  always_comb begin
    state_next        = state;
    s_tready          = 1'b0;
    out_load          = 1'b0;
    cell_we           = 1'b0;
    cell_waddr        = idx_r[CAW-1:0];
    cell_wdata        = m_slot;
    cell_raddr        = in_idx[CAW-1:0];
    pal_we            = 1'b0;
    pal_waddr         = old_slot;
    pal_wdata         = {old_voxel, left};
    pal_raddr         = cell_rdata;
    slots_in_use_next = slots_in_use;
    wr2_slot_next     = wr2_slot;
    wr2_word_next     = wr2_word;
    res_voxel_next    = res_voxel;
    res_slot_next     = res_slot;
    res_status_next   = res_status;

    unique case (state)
      ST_CLEAR: begin
        // Every cell points to slot 0, which holds voxel 0 and all references.
        cell_we    = 1'b1;
        cell_waddr = clr;
        cell_wdata = '0;
        pal_we     = 1'b1;
        pal_waddr  = '0;
        pal_wdata  = {VW'(0), CW'(CELLS)};
        if (clr == CAW'(MEMCELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_range) begin
            state_next = ST_CELL;
          end else begin
            res_voxel_next  = '0;
            res_slot_next   = '0;
            res_status_next = STATUS_OK;
            state_next      = ST_DONE;
          end
        end
      end
      ST_CELL: begin
        pal_raddr  = cell_rdata;
        state_next = ST_OLD;
      end
      ST_OLD: begin
        pal_raddr = '0;
        if (mode_r == MODE_WRITE) begin
          state_next = ST_SCAN;
        end else begin
          res_voxel_next  = rd_voxel;
          res_slot_next   = old_slot;
          res_status_next = STATUS_OK;
          state_next      = ST_DONE;
        end
      end
      ST_SCAN: begin
        pal_raddr = chk_inc[SW-1:0];
        if (scan_hit || scan_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (hit) begin
          cell_we         = 1'b1;
          cell_wdata      = m_slot;
          res_voxel_next  = val_r;
          res_slot_next   = m_slot;
          res_status_next = STATUS_OK;
          pal_we          = 1'b1;
          if (m_slot == old_slot) begin
            pal_wdata  = {val_r, left + CW'(1)};
            state_next = ST_DONE;
          end else begin
            wr2_slot_next = m_slot;
            wr2_word_next = {val_r, m_count + CW'(1)};
            state_next    = ST_WR2;
          end
        end else if (left == '0) begin
          // Old slot has no references left: rewrite it in place.
          pal_we          = 1'b1;
          pal_wdata       = {val_r, CW'(1)};
          res_voxel_next  = val_r;
          res_slot_next   = old_slot;
          res_status_next = STATUS_OK;
          state_next      = ST_DONE;
        end else if (free_ok || (slots_in_use < UW'(PALETTE_DEPTH))) begin
          pal_we        = 1'b1;
          cell_we       = 1'b1;
          wr2_slot_next = free_ok ? free_slot : slots_in_use[SW-1:0];
          wr2_word_next = {val_r, CW'(1)};
          cell_wdata    = wr2_slot_next;
          if (!free_ok) begin
            slots_in_use_next = slots_in_use + UW'(1);
          end
          res_voxel_next  = val_r;
          res_slot_next   = wr2_slot_next;
          res_status_next = STATUS_OK;
          state_next      = ST_WR2;
        end else begin
          res_voxel_next  = old_voxel;
          res_slot_next   = old_slot;
          res_status_next = STATUS_FULL;
          state_next      = ST_DONE;
        end
      end
      ST_WR2: begin
        pal_we     = 1'b1;
        pal_waddr  = wr2_slot;
        pal_wdata  = wr2_word;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      slots_in_use <= UW'(1);
      clr          <= '0;
    end else begin
      state        <= state_next;
      slots_in_use <= slots_in_use_next;
      if (state == ST_CLEAR) begin
        clr <= clr + CAW'(1);
      end
    end
  end

  // Item fields, old slot data, scan bookkeeping, the second palette write and the pending result.
  always_ff @(posedge clk) begin
    wr2_slot   <= wr2_slot_next;
    wr2_word   <= wr2_word_next;
    res_voxel  <= res_voxel_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          mode_r <= in_mode;
          idx_r  <= in_idx;
          val_r  <= in_val_full[VW-1:0];
        end
      end
      ST_CELL: begin
        old_slot <= cell_rdata;
      end
      ST_OLD: begin
        old_voxel <= rd_voxel;
        left      <= (rd_count != '0) ? rd_count - CW'(1) : '0;
        chk       <= '0;
        hit       <= 1'b0;
        free_ok   <= 1'b0;
      end
      ST_SCAN: begin
        // The lowest unreferenced slot other than the old one is remembered.
        if (!free_ok && (chk != old_slot) && (rd_count == '0)) begin
          free_ok   <= 1'b1;
          free_slot <= chk;
        end
        if (scan_hit) begin
          hit     <= 1'b1;
          m_slot  <= chk;
          m_count <= rd_count;
        end else if (!scan_last) begin
          chk <= chk + SW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_voxel                = '0;
    out_voxel[VW-1:0]        = res_voxel;
    out_slot                 = '0;
    out_slot[SOW-1:0]        = res_slot[SOW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(M_TDATA_W - VOXEL_W - SLOT_W)'(0), out_slot, out_voxel};
      m_tuser <= res_status;
    end
  end

  `PCVS_ASSERT_IMP(a_in_use_range,
    1'b1, (slots_in_use != '0) && (slots_in_use <= UW'(PALETTE_DEPTH)))
  `PCVS_ASSERT_IMP(a_scan_in_use, state == ST_SCAN, UW'(chk) < slots_in_use)
  `PCVS_ASSERT_NXT(a_pal_write_in_use, pal_we, UW'($past(pal_waddr)) < slots_in_use)
  `PCVS_ASSERT_IMP(a_full_only_when_full,
    m_tvalid && (m_tuser == STATUS_FULL), slots_in_use == UW'(PALETTE_DEPTH))

endmodule
